// ----- rtl/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and constants for the bitmap page allocator
// Holds the command codes, widths and the command record type.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int PAGE_COUNT = 65536;
  localparam int WORD_BITS  = 64;
  localparam int WORD_COUNT = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int PNUM_W     = ($clog2(PAGE_COUNT) + 1 > 17) ? $clog2(PAGE_COUNT) + 1 : 17;
  localparam int BIT_W      = 6;
  localparam logic [16:0] FREE_MAX = 17'h1FFFF;

  typedef enum logic [1:0] {
    CMD_ALLOC_ONE = 2'd0,
    CMD_ALLOC_RUN = 2'd1,
    CMD_FREE_ONE  = 2'd2,
    CMD_FREE_RUN  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        command;
    logic [15:0] page;
    logic [16:0] count;
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/bpa_if.sv -----
// ----------------------------------------------------------------------------
// bpa_req_if / bpa_rsp_if / bpa_cfg_if: valid-ready channels
// One beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bpa_req_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] page;
  logic [16:0] count;
  modport source (output valid, command, page, count, input ready);
  modport sink   (input valid, command, page, count, output ready);
endinterface

interface bpa_rsp_if (input logic clk);
  logic        valid;
  logic        ready;
  logic        ok;
  logic [15:0] page_index;
  logic [16:0] free_count;
  modport source (output valid, ok, page_index, free_count, input ready);
  modport sink   (input valid, ok, page_index, free_count, output ready);
endinterface

interface bpa_cfg_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [16:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/bpa_front.sv -----
// ----------------------------------------------------------------------------
// bpa_front: command intake queue
// Accepts command beats and holds up to two commands so intake and
// execution stall independently.
// ----------------------------------------------------------------------------
module bpa_front (
  input  logic           clk,
  input  logic           rst,
  bpa_req_if.sink        req,
  output bpa_pkg::req_t  q_data,
  output logic           q_valid,
  input  logic           q_pop
);
  import bpa_pkg::*;

  req_t       slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] fill;
  logic       push;

  assign req.ready = (fill != 2'd2);
  assign push      = req.valid && req.ready;
  assign q_valid   = (fill != 2'd0);
  assign q_data    = slot[rd_ptr];

  // store incoming beat
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{command: cmd_t'(req.command), page: req.page, count: req.count};
    end
  end

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ----- rtl/bpa_back.sv -----
// ----------------------------------------------------------------------------
// bpa_back: bitmap engine
// Walks the bitmap memory one page per cycle within a word for each command,
// one word read per touched word and written back only if changed, and drives results.
// ----------------------------------------------------------------------------
module bpa_back (
  input  logic           clk,
  input  logic           rst,
  input  bpa_pkg::req_t  q_data,
  input  logic           q_valid,
  output logic           q_pop,
  input  logic [16:0]    page_limit,
  bpa_rsp_if.source      rsp
);
  import bpa_pkg::*;

  logic [WORD_BITS-1:0] mem [WORD_COUNT];
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] rd_data;
  logic                 word_dirty;
  logic [WADDR_W-1:0]   word_addr;
  logic [WADDR_W-1:0]   clr_addr;

  state_t            state;
  state_t            state_next;
  req_t              cur;
  logic [PNUM_W-1:0] pos;
  logic [PNUM_W-1:0] limit;
  logic [PNUM_W-1:0] run_start;
  logic [16:0]       run_len;
  logic              second_pass;
  logic              marking;
  logic              found;
  logic [16:0]       free_total;
  logic [15:0]       hint;
  logic              res_ok;
  logic [15:0]       res_idx;
  logic              out_valid;

  logic [PNUM_W-1:0] total;
  logic [PNUM_W-1:0] pos_inc;
  logic [PNUM_W-1:0] wrap_lim;
  logic              bit_used;
  logic [BIT_W-1:0]  bit_sel;
  logic              at_end;
  logic              word_end;
  logic              one_hit;
  logic              run_hit;
  logic [PNUM_W:0]   fr_end;

  assign total = (int'(page_limit) > PAGE_COUNT) ? PNUM_W'(PAGE_COUNT)
                                                 : PNUM_W'(page_limit);
  assign pos_inc  = pos + PNUM_W'(1);
  assign wrap_lim = (PNUM_W'(hint) < total) ? PNUM_W'(hint) : total;
  assign bit_sel  = pos[BIT_W-1:0];
  assign bit_used = word[bit_sel];
  assign at_end   = (pos >= limit);
  assign word_end = (pos_inc[BIT_W-1:0] == '0);
  assign one_hit  = (cur.command == CMD_ALLOC_ONE) && !bit_used;
  assign run_hit  = (cur.command == CMD_ALLOC_RUN) && !marking && !bit_used &&
                    (run_len + 17'd1 == cur.count);
  assign fr_end   = (PNUM_W+1)'(q_data.page) + (PNUM_W+1)'(q_data.count);

  assign rsp.valid      = out_valid;
  assign rsp.ok         = res_ok;
  assign rsp.page_index = res_idx;
  assign rsp.free_count = free_total;

  // memory: one read port, one write port
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      mem[clr_addr] <= '1;
    end else if (state == ST_WRITE && word_dirty) begin
      mem[word_addr] <= word;
    end
    rd_data <= mem[pos[BIT_W +: WADDR_W]];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      ST_CLEAR: if (clr_addr == WADDR_W'(WORD_COUNT - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (q_valid && !out_valid) begin
          q_pop      = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ:  state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_SCAN;
      ST_SCAN:  if (at_end || word_end || one_hit || run_hit) state_next = ST_WRITE;
      ST_WRITE: begin
        if (found) begin
          state_next = ST_DONE;
        end else if (!at_end) begin
          state_next = ST_READ;
        end else if (cur.command == CMD_ALLOC_ONE && !second_pass && wrap_lim != '0) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      free_total <= '0;
      hint       <= '0;
      out_valid  <= 1'b0;
      word_dirty <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: clr_addr <= clr_addr + WADDR_W'(1);
        ST_IDLE: begin
          if (q_pop) begin
            cur         <= q_data;
            word_dirty  <= 1'b0;
            second_pass <= 1'b0;
            marking     <= 1'b0;
            found       <= 1'b0;
            run_len     <= '0;
            run_start   <= '0;
            res_ok      <= 1'b0;
            res_idx     <= 16'd0;
            unique case (q_data.command)
              CMD_ALLOC_ONE: begin
                pos   <= PNUM_W'(hint);
                limit <= total;
              end
              CMD_ALLOC_RUN: begin
                pos   <= '0;
                limit <= (q_data.count == 17'd0 || PNUM_W'(q_data.count) > total)
                         ? '0 : total;
              end
              CMD_FREE_ONE: begin
                res_ok  <= 1'b1;
                res_idx <= q_data.page;
                pos     <= PNUM_W'(q_data.page);
                limit   <= (PNUM_W'(q_data.page) < total) ? PNUM_W'(q_data.page) + PNUM_W'(1)
                                                          : PNUM_W'(q_data.page);
              end
              CMD_FREE_RUN: begin
                res_ok  <= 1'b1;
                res_idx <= q_data.page;
                pos     <= PNUM_W'(q_data.page);
                limit   <= (fr_end > (PNUM_W+1)'(total)) ? total : PNUM_W'(fr_end);
              end
              default: ;
            endcase
          end
        end
        ST_READ: ;
        ST_LOAD: begin
          word       <= rd_data;
          word_addr  <= pos[BIT_W +: WADDR_W];
          word_dirty <= 1'b0;
        end
        ST_SCAN: begin
          if (!at_end) begin
            pos <= pos_inc;
            if (marking) begin
              // mark the allocated run used
              word[bit_sel] <= 1'b1;
              word_dirty    <= 1'b1;
            end else begin
              unique case (cur.command)
                CMD_ALLOC_ONE: if (!bit_used) begin
                  word[bit_sel] <= 1'b1;
                  word_dirty    <= 1'b1;
                  hint          <= pos[15:0];
                  res_ok        <= 1'b1;
                  res_idx       <= pos[15:0];
                  free_total    <= (free_total > 17'd1) ? free_total - 17'd1 : 17'd0;
                  found         <= 1'b1;
                end
                CMD_ALLOC_RUN: begin
                  if (bit_used) begin
                    run_len   <= '0;
                    run_start <= pos_inc;
                  end else if (run_hit) begin
                    // run found: rewind to its start and mark it
                    res_ok     <= 1'b1;
                    res_idx    <= run_start[15:0];
                    free_total <= (free_total > cur.count) ? free_total - cur.count : 17'd0;
                    marking    <= 1'b1;
                    pos        <= run_start;
                    limit      <= pos_inc;
                  end else begin
                    run_len <= run_len + 17'd1;
                  end
                end
                CMD_FREE_ONE, CMD_FREE_RUN: begin
                  if (bit_used) begin
                    word[bit_sel] <= 1'b0;
                    word_dirty    <= 1'b1;
                    if (free_total < FREE_MAX) free_total <= free_total + 17'd1;
                    if (pos < PNUM_W'(hint)) hint <= pos[15:0];
                  end
                end
                default: ;
              endcase
            end
          end
        end
        ST_WRITE: begin
          word_dirty <= 1'b0;
          // wrap to page zero, stop at old hint
          if (!found && at_end && cur.command == CMD_ALLOC_ONE && !second_pass) begin
            second_pass <= 1'b1;
            pos         <= '0;
            limit       <= wrap_lim;
          end
        end
        ST_DONE:  out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/bitmap_page_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_page_allocator: bitmap page-frame allocator
// Front queue of commands feeding a bitmap walking engine.
// ----------------------------------------------------------------------------
// Usage:
//   req: command beats (command, page, count). rsp: one result beat per
//   command (ok, page_index, free_count). cfg: writes the managed page
//   total; write only while nothing is in flight.
//   The engine walks the bitmap memory one page per cycle while scanning a
//   word; each 64-page word touched is read, loaded and then written back if
//   changed. Allocate-one searches from the hint to the managed total, then
//   wraps to page zero and stops at the hint; allocate-run searches for the
//   run, then walks it again to mark it; frees walk the given pages. An
//   allocate-run of zero or of more than the total fails without a scan.
//   One command executes at a time. After reset a clearing pass marks every
//   page used, one 64-page word per cycle, while commands only queue.
//   Commands queue two deep; a stalled result holds the engine, and the
//   queue keeps accepting until full, then drops req.ready.
// ----------------------------------------------------------------------------
module bitmap_page_allocator (
  input  logic      clk,
  input  logic      rst,
  bpa_req_if.sink   req,
  bpa_rsp_if.source rsp,
  bpa_cfg_if.sink   cfg
);
  import bpa_pkg::*;

  req_t        q_data;
  logic        q_valid;
  logic        q_pop;
  logic [16:0] page_limit;

  // hold configuration register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst)            page_limit <= '0;
    else if (cfg.valid) page_limit <= cfg.data;
  end

  bpa_front u_front (
    .clk(clk), .rst(rst), .req(req),
    .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
  );

  bpa_back u_back (
    .clk(clk), .rst(rst), .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop),
    .page_limit(page_limit), .rsp(rsp)
  );

endmodule
